// ===== design/uer_pkg.sv =====
`default_nettype none

package uer_pkg;

  // Counter width default and the limits the design is built for.
  localparam int CounterWidthDefault = 20;

  // Field widths fixed by the interface.
  localparam int TrigWidthW  = 8;
  localparam int TimeoutW    = 20;
  localparam int DistCmW     = 10;
  localparam int DistQ4W     = 14;
  localparam int TicksW      = 16;  // 58 * 1023 fits in 16 bits
  localparam int RemW        = 5;   // remainder below 29

  // Timing constants.
  localparam int PreLowTicks = 2;
  localparam int CmDivisor   = 58;

  // One tick of echo adds 16/58 = 8/29 sixteenths of a centimeter.
  localparam int QuotStep    = 8;
  localparam int QuotDiv     = 29;

  // Reset values of the configuration registers.
  localparam logic [TrigWidthW-1:0] TrigWidthReset = 8'd10;
  localparam logic [TimeoutW-1:0]   TimeoutReset   = 20'd30000;
  localparam logic [DistCmW-1:0]    MinDistReset   = 10'd2;
  localparam logic [DistCmW-1:0]    MaxDistReset   = 10'd400;

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    RegTrigWidth = 2'd0,
    RegTimeout   = 2'd1,
    RegMinDist   = 2'd2,
    RegMaxDist   = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    StatusOk     = 2'd0,
    StatusNoEcho = 2'd1,
    StatusRange  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    PhIdle     = 3'd0,
    PhPreLow   = 3'd1,
    PhTrig     = 3'd2,
    PhWaitLow  = 3'd3,
    PhWaitRise = 3'd4,
    PhMeasure  = 3'd5
  } phase_t;

  // Settings handed from the register block to the measurement core.
  typedef struct packed {
    logic [TrigWidthW-1:0] trig_width;  // already forced to at least one
    logic [TicksW-1:0]     lo_ticks;    // 58 * min_distance_cm
    logic [TicksW-1:0]     hi_ticks;    // 58 * max_distance_cm
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic                  trigger_level;
    logic                  busy_res;
    logic                  done_res;
    status_t               status;
    logic [DistQ4W-1:0]    distance_q4;
  } res_t;

endpackage

`default_nettype wire

// ===== design/uer_cfg.sv =====
`default_nettype none

module uer_cfg
  import uer_pkg::*;
#(
  parameter int COUNTER_WIDTH = CounterWidthDefault
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [3:0]               paddr,
  input  wire logic [31:0]              pwdata,
  output logic      [31:0]              prdata,
  output logic                          pready,
  output cfg_t                          cfg,
  output logic      [COUNTER_WIDTH-1:0] limit
);

  localparam int CmpW = (COUNTER_WIDTH > TimeoutW) ? COUNTER_WIDTH : TimeoutW;

  logic [TrigWidthW-1:0] trigger_width_us;
  logic [TimeoutW-1:0]   timeout_us;
  logic [DistCmW-1:0]    min_distance_cm;
  logic [DistCmW-1:0]    max_distance_cm;
  logic [TicksW-1:0]     lo_ticks;
  logic [TicksW-1:0]     hi_ticks;
  logic                  wr_en;
  reg_idx_t              wr_idx;
  logic [CmpW-1:0]       timeout_ext;
  logic [CmpW-1:0]       cmax_ext;
  logic [TimeoutW-1:0]   timeout_nz;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign wr_idx = reg_idx_t'(paddr[3:2]);

  // The range limits are kept in ticks so the core compares echo width directly.
  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_width_us <= TrigWidthReset;
      timeout_us       <= TimeoutReset;
      min_distance_cm  <= MinDistReset;
      max_distance_cm  <= MaxDistReset;
      lo_ticks         <= TicksW'(CmDivisor * MinDistReset);
      hi_ticks         <= TicksW'(CmDivisor * MaxDistReset);
    end else if (wr_en) begin
      case (wr_idx)
        RegTrigWidth: trigger_width_us <= pwdata[TrigWidthW-1:0];
        RegTimeout:   timeout_us       <= pwdata[TimeoutW-1:0];
        RegMinDist: begin
          min_distance_cm <= pwdata[DistCmW-1:0];
          lo_ticks        <= TicksW'(TicksW'(CmDivisor) * TicksW'(pwdata[DistCmW-1:0]));
        end
        RegMaxDist: begin
          max_distance_cm <= pwdata[DistCmW-1:0];
          hi_ticks        <= TicksW'(TicksW'(CmDivisor) * TicksW'(pwdata[DistCmW-1:0]));
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (wr_idx)
      RegTrigWidth: prdata = 32'(trigger_width_us);
      RegTimeout:   prdata = 32'(timeout_us);
      RegMinDist:   prdata = 32'(min_distance_cm);
      RegMaxDist:   prdata = 32'(max_distance_cm);
      default:      prdata = '0;
    endcase
  end

  // A zero timeout acts as one tick; a timeout past the counter range is clamped.
  assign timeout_nz  = (timeout_us == '0) ? TimeoutW'(1) : timeout_us;
  assign timeout_ext = CmpW'(timeout_nz);
  assign cmax_ext    = CmpW'({COUNTER_WIDTH{1'b1}});
  assign limit       = (timeout_ext > cmax_ext) ? COUNTER_WIDTH'(cmax_ext)
                                                : COUNTER_WIDTH'(timeout_ext);

  assign cfg.trig_width = (trigger_width_us == '0) ? TrigWidthW'(1) : trigger_width_us;
  assign cfg.lo_ticks   = lo_ticks;
  assign cfg.hi_ticks   = hi_ticks;

endmodule

`default_nettype wire

// ===== design/uer_core.sv =====
`default_nettype none

module uer_core
  import uer_pkg::*;
#(
  parameter int COUNTER_WIDTH = CounterWidthDefault
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     accept,
  input  wire logic                     start_req,
  input  wire logic                     echo_level,
  input  wire cfg_t                     cfg,
  input  wire logic [COUNTER_WIDTH-1:0] limit,
  output res_t                          res
);

  localparam int CW = COUNTER_WIDTH;

  phase_t             phase, phase_next;
  logic [CW-1:0]      elapsed_ticks, elapsed_ticks_next;
  logic [CW-1:0]      echo_width, echo_width_next;
  logic [DistQ4W-1:0] quot, quot_next;
  logic [RemW-1:0]    rem, rem_next;

  logic [CW-1:0]      elapsed_inc;
  logic [CW-1:0]      width_inc;
  logic [RemW:0]      rem_sum;
  logic [DistQ4W-1:0] quot_step;
  logic [RemW-1:0]    rem_step;
  logic               finished;
  logic               in_range;

  assign elapsed_inc = (elapsed_ticks == '1) ? elapsed_ticks : elapsed_ticks + 1'b1;
  assign width_inc   = (echo_width == '1) ? echo_width : echo_width + 1'b1;

  // Running quotient of width*8/29, advanced one tick at a time.
  assign rem_sum   = (RemW + 1)'(rem) + (RemW + 1)'(QuotStep);
  assign quot_step = (rem_sum >= (RemW + 1)'(QuotDiv)) ? quot + 1'b1 : quot;
  assign rem_step  = (rem_sum >= (RemW + 1)'(QuotDiv)) ? RemW'(rem_sum - (RemW + 1)'(QuotDiv))
                                                       : RemW'(rem_sum);

  assign in_range = (echo_width >= CW'(cfg.lo_ticks)) && (echo_width <= CW'(cfg.hi_ticks));

  always_comb begin
    phase_next         = phase;
    elapsed_ticks_next = elapsed_ticks;
    echo_width_next    = echo_width;
    quot_next          = quot;
    rem_next           = rem;
    finished           = 1'b0;
    res                = '0;
    case (phase)
      PhIdle: begin
        if (start_req) begin
          res.busy_res       = 1'b1;
          elapsed_ticks_next = CW'(1);
          echo_width_next    = '0;
          quot_next          = '0;
          rem_next           = '0;
          if (1 >= PreLowTicks) begin
            phase_next         = PhTrig;
            elapsed_ticks_next = '0;
          end else begin
            phase_next = PhPreLow;
          end
        end
      end
      PhPreLow: begin
        res.busy_res       = 1'b1;
        elapsed_ticks_next = elapsed_inc;
        if (elapsed_inc >= CW'(PreLowTicks)) begin
          phase_next         = PhTrig;
          elapsed_ticks_next = '0;
        end
      end
      PhTrig: begin
        res.busy_res       = 1'b1;
        res.trigger_level  = 1'b1;
        elapsed_ticks_next = elapsed_inc;
        if (elapsed_inc >= CW'(cfg.trig_width)) begin
          phase_next         = PhWaitLow;
          elapsed_ticks_next = '0;
        end
      end
      PhWaitLow, PhWaitRise, PhMeasure: begin
        elapsed_ticks_next = elapsed_inc;
        if (phase == PhWaitLow) begin
          if (!echo_level) begin
            phase_next = PhWaitRise;
          end
        end else if (phase == PhWaitRise) begin
          if (echo_level) begin
            phase_next      = PhMeasure;
            echo_width_next = CW'(1);
            quot_next       = '0;
            rem_next        = RemW'(QuotStep);
          end
        end else if (echo_level) begin
          echo_width_next = width_inc;
          quot_next       = quot_step;
          rem_next        = rem_step;
        end else begin
          // Falling edge ends the measurement, even on the timeout tick.
          finished = 1'b1;
          if (in_range) begin
            res.status      = StatusOk;
            res.distance_q4 = quot;
          end else begin
            res.status = StatusRange;
          end
        end
        if (!finished && (elapsed_inc >= limit)) begin
          finished        = 1'b1;
          res.status      = StatusNoEcho;
          res.distance_q4 = '0;
        end
        if (finished) begin
          res.done_res       = 1'b1;
          phase_next         = PhIdle;
          elapsed_ticks_next = '0;
          echo_width_next    = '0;
        end else begin
          res.busy_res = 1'b1;
        end
      end
      default: begin
        phase_next         = PhIdle;
        elapsed_ticks_next = '0;
        echo_width_next    = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PhIdle;
      elapsed_ticks <= '0;
      echo_width    <= '0;
      quot          <= '0;
      rem           <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      elapsed_ticks <= elapsed_ticks_next;
      echo_width    <= echo_width_next;
      quot          <= quot_next;
      rem           <= rem_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/uer_out.sv =====
`default_nettype none

module uer_out
  import uer_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      accept,
  input  wire res_t res,
  output logic      out_valid,
  input  wire logic out_stall,
  output res_t      out_res
);

  // A new item is taken whenever the held result is gone or leaving now.
  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= accept | (out_valid & out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_res <= res;
    end
  end

endmodule

`default_nettype wire

// ===== design/ultrasonic_echo_ranger_top.sv =====
`default_nettype none

// Ultrasonic time-of-flight ranger. Each input item is one microsecond tick
// carrying a start request and the sampled echo level, and each item yields
// exactly one result item with the trigger pin level, busy and done flags,
// a status code and the distance in sixteenths of a centimeter. A start
// request seen while idle holds the trigger low for two ticks (the start
// tick and one more), then high for trigger_width_us ticks. After that the
// echo is watched: if it is already high the block waits for it to go low,
// then waits for a rising edge and counts the high width. The timeout counts
// every tick from the end of the trigger; a falling edge on the timeout tick
// still completes the measurement. On the falling edge the distance is
// floor(width*16/58), kept as a running quotient that advances once per
// echo tick, so no divider sits in any path. The width is checked against
// 58 times the minimum and maximum distance, which are precomputed when
// those registers are written. Status is 0 for ok, 1 for no echo and 2 for
// out of range; the distance is zero unless status is ok and done is set.
// The block takes one item per clock cycle unless stalled; the result sits
// in one output register, so a new item is accepted while the previous
// result is still being taken and stall is raised only when that register
// is full and held. A result shows in the cycle after its tick is taken.
// No clearing pass follows reset. Configuration registers sit at byte
// addresses 0, 4, 8 and 12 and should be written only while the block is
// idle. COUNTER_WIDTH sets the width of the tick counters, which saturate;
// a timeout above their range is clamped to their maximum.

module ultrasonic_echo_ranger_top
  import uer_pkg::*;
#(
  parameter int COUNTER_WIDTH = CounterWidthDefault
) (
  input  wire logic                clk,
  input  wire logic                rst,
  // Configuration port
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [3:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic      [31:0]         prdata,
  output logic                     pready,
  // Tick input channel
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                start_req,
  input  wire logic                echo_level,
  // Result channel
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     trigger_level,
  output logic                     busy_res,
  output logic                     done_res,
  output logic      [1:0]          status,
  output logic      [DistQ4W-1:0]  distance_q4
);

  cfg_t                     cfg;
  logic [COUNTER_WIDTH-1:0] limit;
  logic                     accept;
  res_t                     res;
  res_t                     out_res;

  uer_cfg #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .limit   (limit)
  );

  uer_core #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .start_req  (start_req),
    .echo_level (echo_level),
    .cfg        (cfg),
    .limit      (limit),
    .res        (res)
  );

  uer_out u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .accept    (accept),
    .res       (res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign trigger_level = out_res.trigger_level;
  assign busy_res      = out_res.busy_res;
  assign done_res      = out_res.done_res;
  assign status        = out_res.status;
  assign distance_q4   = out_res.distance_q4;

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import uer_pkg::*;

  // The block is built with its default counter width, so counters saturate here.
  localparam int unsigned CntMax = (1 << CounterWidthDefault) - 1;
  // Cycles the result side holds off in one stretch, long enough to fill the block.
  localparam int HoldoffCycles = 80;
  // Generous bound on the whole run, several times the slowest correct run.
  localparam int CycleLimit = 1000000;

  // Ranging predictor and the queue of per-tick results it expects.
  class ranger_scoreboard;
    logic [TrigWidthW-1:0] trig_width;
    logic [TimeoutW-1:0]   timeout;
    logic [DistCmW-1:0]    min_cm;
    logic [DistCmW-1:0]    max_cm;
    phase_t                phase;
    int unsigned           elapsed;
    int unsigned           echo_ticks;
    res_t                  due_results[$];
    int                    mismatches;

    function new();
      trig_width = TrigWidthReset;
      timeout    = TimeoutReset;
      min_cm     = MinDistReset;
      max_cm     = MaxDistReset;
      phase      = PhIdle;
      elapsed    = 0;
      echo_ticks = 0;
      mismatches = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] value);
      case (idx)
        RegTrigWidth: trig_width = value[TrigWidthW-1:0];
        RegTimeout:   timeout    = value[TimeoutW-1:0];
        RegMinDist:   min_cm     = value[DistCmW-1:0];
        RegMaxDist:   max_cm     = value[DistCmW-1:0];
        default: ;
      endcase
    endfunction

    function bit is_idle();
      return phase == PhIdle;
    endfunction

    function bit in_trigger();
      return phase == PhPreLow || phase == PhTrig;
    endfunction

    function int unsigned bump(int unsigned v);
      return (v >= CntMax) ? CntMax : v + 1;
    endfunction

    // Advance the predicted ranger by one accepted tick and queue its result.
    function void note_tick(logic start, logic echo);
      res_t        r;
      int unsigned tw;
      int unsigned lim;
      int unsigned lo;
      int unsigned hi;
      bit          fin;
      r   = '0;
      fin = 1'b0;
      tw  = (trig_width == 0) ? 1 : trig_width;
      lim = (timeout == 0) ? 1 : timeout;
      if (lim > CntMax) lim = CntMax;
      case (phase)
        PhIdle: begin
          if (start) begin
            r.busy_res = 1'b1;
            elapsed    = 1;
            echo_ticks = 0;
            if (elapsed >= PreLowTicks) begin
              phase   = PhTrig;
              elapsed = 0;
            end else begin
              phase = PhPreLow;
            end
          end
        end
        PhPreLow: begin
          r.busy_res = 1'b1;
          elapsed    = bump(elapsed);
          if (elapsed >= PreLowTicks) begin
            phase   = PhTrig;
            elapsed = 0;
          end
        end
        PhTrig: begin
          r.busy_res      = 1'b1;
          r.trigger_level = 1'b1;
          elapsed         = bump(elapsed);
          if (elapsed >= tw) begin
            phase   = PhWaitLow;
            elapsed = 0;
          end
        end
        PhWaitLow, PhWaitRise, PhMeasure: begin
          elapsed = bump(elapsed);
          if (phase == PhWaitLow) begin
            if (!echo) phase = PhWaitRise;
          end else if (phase == PhWaitRise) begin
            if (echo) begin
              phase      = PhMeasure;
              echo_ticks = 1;
            end
          end else if (echo) begin
            echo_ticks = bump(echo_ticks);
          end else begin
            lo  = CmDivisor * min_cm;
            hi  = CmDivisor * max_cm;
            fin = 1'b1;
            if (echo_ticks < lo || echo_ticks > hi) begin
              r.status = StatusRange;
            end else begin
              r.status      = StatusOk;
              r.distance_q4 = DistQ4W'((echo_ticks * 16) / CmDivisor);
            end
          end
          if (!fin && elapsed >= lim) begin
            fin           = 1'b1;
            r.status      = StatusNoEcho;
            r.distance_q4 = '0;
          end
          if (fin) begin
            r.done_res = 1'b1;
            phase      = PhIdle;
            elapsed    = 0;
            echo_ticks = 0;
          end else begin
            r.busy_res = 1'b1;
          end
        end
        default: begin
          phase      = PhIdle;
          elapsed    = 0;
          echo_ticks = 0;
        end
      endcase
      due_results.push_back(r);
    endfunction

    task report(string what, res_t got, res_t want);
      mismatches++;
      $display("MISMATCH %s: got trig %0b busy %0b done %0b status %0d dist %0d, ",
               what, got.trigger_level, got.busy_res, got.done_res, got.status,
               got.distance_q4,
               "want trig %0b busy %0b done %0b status %0d dist %0d",
               want.trigger_level, want.busy_res, want.done_res,
               want.status, want.distance_q4);
    endtask

    task check_result(res_t got);
      res_t want;
      if (due_results.size() == 0) begin
        report("result with none expected", got, '0);
        return;
      end
      want = due_results.pop_front();
      if (got.trigger_level !== want.trigger_level || got.busy_res !== want.busy_res ||
          got.done_res !== want.done_res || got.status !== want.status ||
          got.distance_q4 !== want.distance_q4)
        report("result", got, want);
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               start_req = 1'b0;
  logic               echo_level = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               trigger_level;
  logic               busy_res;
  logic               done_res;
  logic [1:0]         status;
  logic [DistQ4W-1:0] distance_q4;

  ranger_scoreboard sb = new();

  // Random idling on both sides; cleared for the last part of the run.
  bit idling_on = 1'b1;
  // Raised by the stimulus to make the result side hold off for a long stretch.
  bit holdoff_req = 1'b0;
  int tick_count = 0;
  int cycle_count = 0;

  ultrasonic_echo_ranger_top uut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .start_req     (start_req),
    .echo_level    (echo_level),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .trigger_level (trigger_level),
    .busy_res      (busy_res),
    .done_res      (done_res),
    .status        (status),
    .distance_q4   (distance_q4)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 0;
  end

  function automatic logic rbit();
    return 1'($urandom_range(0, 1));
  endfunction

  // Register write over the configuration port: setup cycle, then the access
  // cycle, with the write landing on the edge where pready is seen high. The
  // bus then idles so that back-to-back writes each get their own setup.
  task automatic reg_write(input reg_idx_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, value);
    @(posedge clk);
  endtask

  // Offer one tick item and hold it until accepted. The valid line is only
  // lowered inside a gap, so a valid that stays high is never toggled in a step.
  task automatic send_tick(input logic start, input logic echo);
    if (idling_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    start_req  <= start;
    echo_level <= echo;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_tick(start, echo);
    tick_count++;
  endtask

  // One ranging cycle: start, trigger ticks with random content, then an echo
  // that is high for pre_hi ticks, low for low_len, high for hi_len. A noisy
  // cycle adds random echo ticks. Any cycle still running is then walked to its
  // end by giving the edge the predicted phase is waiting for.
  task automatic range_once(input int pre_hi, input int low_len, input int hi_len,
                            input bit noisy);
    int i;
    send_tick(1'b1, rbit());
    while (sb.in_trigger()) send_tick(rbit(), rbit());
    for (i = 0; i < pre_hi && !sb.is_idle(); i++) send_tick(rbit(), 1'b1);
    for (i = 0; i < low_len && !sb.is_idle(); i++) send_tick(rbit(), 1'b0);
    for (i = 0; i < hi_len && !sb.is_idle(); i++) send_tick(rbit(), 1'b1);
    if (noisy)
      for (i = 0; i < 40 && !sb.is_idle(); i++) send_tick(rbit(), rbit());
    while (!sb.is_idle()) send_tick(rbit(), sb.phase == PhWaitRise);
  endtask

  // Bring the block to rest before a register write: no item offered, every
  // expected result taken, and the output register left to drain.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin : result_taker
    int burst;
    burst = 0;
    forever begin
      @(posedge clk);
      if (holdoff_req) begin
        out_stall <= 1'b1;
        repeat (HoldoffCycles) @(posedge clk);
        holdoff_req = 1'b0;
        burst = 0;
        out_stall <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        out_stall <= 1'b1;
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 14) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Every accepted result is checked against the oldest expectation.
  initial begin : result_monitor
    res_t got;
    forever begin
      @(posedge clk);
      if (rst === 1'b0 && out_valid === 1'b1 && out_stall === 1'b0) begin
        got.trigger_level = trigger_level;
        got.busy_res      = busy_res;
        got.done_res      = done_res;
        got.status        = status_t'(status);
        got.distance_q4   = distance_q4;
        sb.check_result(got);
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("ultrasonic_echo_ranger_top test failed");
    $finish;
  end

  initial begin : stimulus
    int p;
    int budget;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Registers at their reset values: echo already high when the watch
    // begins, so the block must wait for it to drop before the pulse, which is
    // too short for the two centimeter minimum.
    range_once(2, 2, 30, 1'b0);

    // Zero trigger width acts as one tick and zero timeout as one tick, so the
    // first watched tick ends in no echo.
    settle();
    reg_write(RegTrigWidth, 32'd0);
    reg_write(RegTimeout, 32'd0);
    reg_write(RegMinDist, 32'd0);
    reg_write(RegMaxDist, 32'd1023);
    range_once(0, 1, 5, 1'b0);

    // Timeout of five ticks: the falling edge lands exactly on the timeout tick
    // and must win; then a pulse that outlasts the timeout.
    settle();
    reg_write(RegTrigWidth, 32'd1);
    reg_write(RegTimeout, 32'd5);
    reg_write(RegMaxDist, 32'd1);
    range_once(0, 1, 3, 1'b0);
    range_once(0, 1, 10, 1'b0);

    // Minimum above maximum: every echo is out of range.
    settle();
    reg_write(RegTimeout, 32'd300);
    reg_write(RegMinDist, 32'd3);
    range_once(0, 1, 20, 1'b0);

    // Largest timeout and full range: a mid-length pulse gives its distance,
    // then the shortest pulse gives zero.
    settle();
    reg_write(RegTrigWidth, 32'd3);
    reg_write(RegTimeout, 32'd1048575);
    reg_write(RegMinDist, 32'd0);
    reg_write(RegMaxDist, 32'd1023);
    range_once(0, 1, 60, 1'b0);
    range_once(0, 0, 1, 1'b0);

    // Random part: several register settings, each running well-formed ranging
    // cycles with random content and an occasional noisy echo.
    for (p = 0; p < 5; p++) begin
      settle();
      if (p == 4) idling_on = 1'b0;
      reg_write(RegTrigWidth, (p == 3) ? 32'd20 : $urandom_range(0, 12));
      reg_write(RegTimeout, (p == 4) ? 32'd1 : $urandom_range(40, 320));
      reg_write(RegMinDist, (p == 4) ? 32'd1023 : $urandom_range(0, 2));
      reg_write(RegMaxDist, (p == 0) ? 32'd1023 : $urandom_range(1, 5));
      // The result side stops for a long while as this setting begins, and the
      // sender keeps offering ticks until the block pushes back.
      if (p == 1) holdoff_req = 1'b1;
      budget = tick_count + 30;
      while (tick_count < budget) begin
        repeat ($urandom_range(0, 3)) send_tick(1'b0, rbit());
        range_once(($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0,
                   $urandom_range(0, 6),
                   ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8)
                                               : $urandom_range(20, 80),
                   $urandom_range(0, 7) == 0);
        // In one setting, the sender waits for every expected result after each ranging cycle.
        if (p == 2 && sb.due_results.size() != 0) begin
          in_valid <= 1'b0;
          while (sb.due_results.size() != 0) @(posedge clk);
        end
      end
    end

    in_valid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.due_results.size() == 0) begin
      $display("ultrasonic_echo_ranger_top test passed");
    end else begin
      $display("ultrasonic_echo_ranger_top test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/uer_pkg.sv
design/uer_cfg.sv
design/uer_core.sv
design/uer_out.sv
design/ultrasonic_echo_ranger_top.sv
test/tb.sv
